>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define DGB_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dgb checker: same-cycle implication violated");

// Next-cycle implication, switched off while reset is high.
`define DGB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dgb checker: next-cycle implication violated");

// Next-cycle implication that is also checked across reset.
`define DGB_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("dgb checker: next-cycle check after reset violated");

`endif

>>> hdl/dgb_pkg.sv
// ----------------------------------------------------------------------------
// dgb_pkg
// Shared constants and types of the depth-to-gray converter with band minima.
// ----------------------------------------------------------------------------
package dgb_pkg;

   // Frame geometry limits.
   localparam int MAX_WIDTH  = 1024;
   localparam int NUM_BANDS  = 4;
   localparam int MAX_HEIGHT = 4096;
   localparam int MIN_HEIGHT = 2 * NUM_BANDS;

   localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int BAND_W = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;

   // Band minima memory: one byte per band and column.
   localparam int MEM_DEPTH = NUM_BANDS * MAX_WIDTH;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);

   // Payload widths.
   localparam int SAMPLE_W = 16;
   localparam int GRAY_W   = 8;

   // Pixel scaling constants.
   localparam int DEPTH_STEP_MM = 20;
   localparam int GRAY_MAX      = 255;
   localparam int GRAY_EMPTY    = 0;

   // Samples at or above this limit saturate to the maximum byte.
   localparam int SAT_LIMIT = (GRAY_MAX + 1) * DEPTH_STEP_MM;
   localparam int SMALL_W   = $clog2(SAT_LIMIT);
   // Reciprocal of the distance step, exact for every sample below SAT_LIMIT.
   localparam int DIV_SHIFT = 20;
   localparam int DIV_MUL   = ((1 << DIV_SHIFT) + DEPTH_STEP_MM - 1)
                              / DEPTH_STEP_MM;
   localparam int DIV_MUL_W = $clog2(DIV_MUL + 1);
   localparam int PROD_W    = SMALL_W + DIV_MUL_W;

   // Configuration registers.
   localparam int WREG_W     = 11;
   localparam int HREG_W     = 13;
   localparam int CSR_DATA_W = (WREG_W > HREG_W) ? WREG_W : HREG_W;
   localparam int WIDTH_RESET  = 640;
   localparam int HEIGHT_RESET = 480;

   typedef enum logic [0:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   // One result as it waits in the output queue.
   typedef struct packed {
      logic [GRAY_W-1:0] gray_byte;
      logic              is_profile;
      logic              end_of_frame;
   } rsp_item_type;

endpackage

>>> hdl/dgb_channels.sv
// ----------------------------------------------------------------------------
// dgb_channels
// Valid/ready channels for depth requests and gray responses.
// ----------------------------------------------------------------------------

// Request channel: one raw depth sample.
interface dgb_req_if import dgb_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] depth_sample;

   modport source (output valid, output depth_sample, input ready);
   modport sink   (input valid, input depth_sample, output ready);
endinterface

// Response channel: one gray byte with its flags.
interface dgb_rsp_if import dgb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [GRAY_W-1:0] gray_byte;
   logic              is_profile;
   logic              end_of_frame;

   modport source (output valid, output gray_byte, output is_profile,
                   output end_of_frame, input ready);
   modport sink   (input valid, input gray_byte, input is_profile,
                   input end_of_frame, output ready);
endinterface

>>> hdl/depth_to_gray_with_band_minima.sv
// ----------------------------------------------------------------------------
// depth_to_gray_with_band_minima
// Converts a raster stream of depth samples into gray bytes and appends,
// in the last rows of each frame, per-column minima of the image bands.
// ----------------------------------------------------------------------------
// The block takes one request per clock while no clearing pass runs and
// the response queue has room, and returns one response per request, in
// order, through the stage-1 registers and the response queue. The minima
// live in a 4096 x 8 memory with one write port and one registered read
// port; each request makes exactly one read-modify-write of that memory,
// and back-to-back requests to the same entry (a frame width of one) are
// served by forwarding the last write. After reset a clearing pass zeroes
// all 4096 entries, one entry a cycle; req_ch.ready stays low during that
// pass while configuration writes are taken as usual. A three-entry
// response queue lets requests keep flowing while a response waits to be taken.
// ----------------------------------------------------------------------------
module depth_to_gray_with_band_minima import dgb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   dgb_req_if.sink               req_ch,
   dgb_rsp_if.source             rsp_ch,
   input  logic                  csr_wr_en,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int QDEPTH = 3;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // ------------------------------------------------------------------
   // Declarations
   // ------------------------------------------------------------------
   logic [COL_W-1:0]   w_last_ff, w_last_in;
   logic [ROW_W-1:0]   h_last_ff, h_last_in;
   logic [ROW_W-1:0]   img_rows_ff, img_rows_in;
   logic [ROW_W-1:0]   band_rows_ff, band_rows_in;

   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [BAND_W-1:0]  band_ff, band_in;
   logic [ROW_W-1:0]   rib_ff, rib_in;

   logic               clr_ff, clr_in;
   logic [ADDR_W-1:0]  clr_addr_ff, clr_addr_in;

   logic               s1_vld_ff, s1_vld_in;
   logic [ADDR_W-1:0]  s1_addr_ff, s1_addr_in;
   logic [GRAY_W-1:0]  s1_gray_ff, s1_gray_in;
   logic               s1_prof_ff, s1_prof_in;
   logic               s1_eof_ff, s1_eof_in;

   logic               fwd_hit_ff, fwd_hit_in;
   logic [GRAY_W-1:0]  fwd_data_ff, fwd_data_in;

   logic [GRAY_W-1:0]  mem [MEM_DEPTH];
   logic [GRAY_W-1:0]  rd_data_ff;

   rsp_item_type       q_ff [QDEPTH];
   logic [QPTR_W-1:0]  q_wr_ff, q_wr_in;
   logic [QPTR_W-1:0]  q_rd_ff, q_rd_in;
   logic [QCNT_W-1:0]  q_cnt_ff, q_cnt_in;

   logic               accept;
   logic               q_push;
   logic               q_pop;
   logic [QCNT_W:0]    q_load;

   logic [WREG_W-1:0]  wv;
   logic [WREG_W-1:0]  w_eff;
   logic [HREG_W-1:0]  hv;
   logic [HREG_W-1:0]  h_eff;

   logic               is_prof;
   logic [ROW_W-1:0]   prof_row;
   logic [BAND_W-1:0]  prof_band;
   logic [BAND_W-1:0]  band_sel;
   logic [ADDR_W-1:0]  s0_addr;
   logic               row_end;
   logic               frame_end;
   logic [ROW_W-1:0]   rib_inc;

   logic               sat;
   logic [PROD_W-1:0]  prod;
   logic [GRAY_W-1:0]  gray_s0;

   logic [GRAY_W-1:0]  entry;
   logic [GRAY_W-1:0]  entry_new;
   logic [GRAY_W-1:0]  rsp_gray;

   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   logic [GRAY_W-1:0]  mem_wdata;

   // ------------------------------------------------------------------
   // Handshake
   // ------------------------------------------------------------------
   // Room is reserved for the request in flight and the one accepted now.
   assign q_load       = {1'b0, q_cnt_ff} + (QCNT_W + 1)'(s1_vld_ff);
   assign req_ch.ready = !clr_ff && (q_load < (QCNT_W + 1)'(QDEPTH));
   assign accept       = req_ch.valid && req_ch.ready;

   // ------------------------------------------------------------------
   // Configuration: clamp on write and keep the derived geometry
   // ------------------------------------------------------------------
   always_comb begin
      wv = csr_wdata[WREG_W-1:0];
      hv = csr_wdata[HREG_W-1:0];

      if (wv == '0) begin
         w_eff = WREG_W'(1);
      end else if (wv > WREG_W'(MAX_WIDTH)) begin
         w_eff = WREG_W'(MAX_WIDTH);
      end else begin
         w_eff = wv;
      end

      if (hv < HREG_W'(MIN_HEIGHT)) begin
         h_eff = HREG_W'(MIN_HEIGHT);
      end else if (hv > HREG_W'(MAX_HEIGHT)) begin
         h_eff = HREG_W'(MAX_HEIGHT);
      end else begin
         h_eff = hv;
      end

      w_last_in    = w_last_ff;
      h_last_in    = h_last_ff;
      img_rows_in  = img_rows_ff;
      band_rows_in = band_rows_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_FRAME_WIDTH: begin
               w_last_in = COL_W'(w_eff - WREG_W'(1));
            end
            CSR_FRAME_HEIGHT: begin
               h_last_in    = ROW_W'(h_eff - HREG_W'(1));
               img_rows_in  = ROW_W'(h_eff - HREG_W'(NUM_BANDS));
               band_rows_in = ROW_W'((h_eff - HREG_W'(NUM_BANDS)) / HREG_W'(NUM_BANDS));
            end
            default: begin
               w_last_in = w_last_ff;
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Stage 0: scale the sample, pick the entry, advance the raster position
   // ------------------------------------------------------------------
   always_comb begin
      sat     = req_ch.depth_sample >= SAMPLE_W'(SAT_LIMIT);
      prod    = PROD_W'(req_ch.depth_sample[SMALL_W-1:0]) * PROD_W'(DIV_MUL);
      gray_s0 = sat ? GRAY_W'(GRAY_MAX) : prod[DIV_SHIFT +: GRAY_W];

      // Profile rows read a band; rows past the last band read the last one.
      is_prof  = row_ff >= img_rows_ff;
      prof_row = row_ff - img_rows_ff;
      if (prof_row >= ROW_W'(NUM_BANDS - 1)) begin
         prof_band = BAND_W'(NUM_BANDS - 1);
      end else begin
         prof_band = prof_row[BAND_W-1:0];
      end
      band_sel = is_prof ? prof_band : band_ff;
      s0_addr  = ADDR_W'(band_sel) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col_ff);

      row_end   = col_ff >= w_last_ff;
      frame_end = row_end && (row_ff >= h_last_ff);
      rib_inc   = rib_ff + ROW_W'(1);

      col_in  = col_ff;
      row_in  = row_ff;
      band_in = band_ff;
      rib_in  = rib_ff;
      if (accept) begin
         if (!row_end) begin
            col_in = col_ff + COL_W'(1);
         end else if (frame_end) begin
            col_in  = '0;
            row_in  = '0;
            band_in = '0;
            rib_in  = '0;
         end else begin
            col_in = '0;
            row_in = row_ff + ROW_W'(1);
            if ((rib_inc >= band_rows_ff) && (band_ff < BAND_W'(NUM_BANDS - 1))) begin
               band_in = band_ff + BAND_W'(1);
               rib_in  = '0;
            end else begin
               rib_in = rib_inc;
            end
         end
      end

      s1_vld_in  = accept;
      s1_addr_in = s0_addr;
      s1_gray_in = gray_s0;
      s1_prof_in = is_prof;
      s1_eof_in  = frame_end;
   end

   // ------------------------------------------------------------------
   // Stage 1: update the entry and write it back
   // ------------------------------------------------------------------
   always_comb begin
      // The memory returns the old byte when the previous request wrote
      // the same entry in the cycle of this read.
      entry = fwd_hit_ff ? fwd_data_ff : rd_data_ff;

      entry_new = entry;
      if (s1_prof_ff) begin
         entry_new = GRAY_W'(GRAY_EMPTY);
      end else if (s1_gray_ff > GRAY_W'(DEPTH_STEP_MM)) begin
         if (entry == GRAY_W'(GRAY_EMPTY)) begin
            if (s1_gray_ff < GRAY_W'(GRAY_MAX)) begin
               entry_new = s1_gray_ff;
            end
         end else if (s1_gray_ff < entry) begin
            entry_new = s1_gray_ff;
         end
      end

      rsp_gray = s1_prof_ff ? entry : s1_gray_ff;

      fwd_hit_in  = s1_vld_ff && accept && (s0_addr == s1_addr_ff);
      fwd_data_in = entry_new;

      // The clearing pass owns the write port until it is done.
      if (clr_ff) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wdata = GRAY_W'(GRAY_EMPTY);
      end else begin
         mem_we    = s1_vld_ff;
         mem_waddr = s1_addr_ff;
         mem_wdata = entry_new;
      end

      clr_in      = clr_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_ff) begin
         clr_addr_in = clr_addr_ff + ADDR_W'(1);
         if (clr_addr_ff == ADDR_W'(MEM_DEPTH - 1)) begin
            clr_in = 1'b0;
         end
      end
   end

   // Band minima memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (accept) begin
         rd_data_ff <= mem[s0_addr];
      end
   end

   // ------------------------------------------------------------------
   // Response queue
   // ------------------------------------------------------------------
   always_comb begin
      q_push = s1_vld_ff;
      q_pop  = (q_cnt_ff != '0) && rsp_ch.ready;

      q_wr_in = q_wr_ff;
      if (q_push) begin
         q_wr_in = (q_wr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : q_wr_ff + QPTR_W'(1);
      end
      q_rd_in = q_rd_ff;
      if (q_pop) begin
         q_rd_in = (q_rd_ff == QPTR_W'(QDEPTH - 1)) ? '0 : q_rd_ff + QPTR_W'(1);
      end
      q_cnt_in = q_cnt_ff + QCNT_W'(q_push) - QCNT_W'(q_pop);
   end

   assign rsp_ch.valid        = q_cnt_ff != '0;
   assign rsp_ch.gray_byte    = q_ff[q_rd_ff].gray_byte;
   assign rsp_ch.is_profile   = q_ff[q_rd_ff].is_profile;
   assign rsp_ch.end_of_frame = q_ff[q_rd_ff].end_of_frame;

   always_ff @(posedge clock) begin
      if (q_push) begin
         q_ff[q_wr_ff] <= '{gray_byte: rsp_gray, is_profile: s1_prof_ff,
                            end_of_frame: s1_eof_ff};
      end
   end

   // ------------------------------------------------------------------
   // Payload registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      s1_addr_ff  <= s1_addr_in;
      s1_gray_ff  <= s1_gray_in;
      s1_prof_ff  <= s1_prof_in;
      s1_eof_ff   <= s1_eof_in;
      fwd_data_ff <= fwd_data_in;
   end

   // ------------------------------------------------------------------
   // Control registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         w_last_ff    <= COL_W'(WIDTH_RESET - 1);
         h_last_ff    <= ROW_W'(HEIGHT_RESET - 1);
         img_rows_ff  <= ROW_W'(HEIGHT_RESET - NUM_BANDS);
         band_rows_ff <= ROW_W'((HEIGHT_RESET - NUM_BANDS) / NUM_BANDS);
         col_ff       <= '0;
         row_ff       <= '0;
         band_ff      <= '0;
         rib_ff       <= '0;
         clr_ff       <= 1'b1;
         clr_addr_ff  <= '0;
         s1_vld_ff    <= 1'b0;
         fwd_hit_ff   <= 1'b0;
         q_wr_ff      <= '0;
         q_rd_ff      <= '0;
         q_cnt_ff     <= '0;
      end else begin
         w_last_ff    <= w_last_in;
         h_last_ff    <= h_last_in;
         img_rows_ff  <= img_rows_in;
         band_rows_ff <= band_rows_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         band_ff      <= band_in;
         rib_ff       <= rib_in;
         clr_ff       <= clr_in;
         clr_addr_ff  <= clr_addr_in;
         s1_vld_ff    <= s1_vld_in;
         fwd_hit_ff   <= fwd_hit_in;
         q_wr_ff      <= q_wr_in;
         q_rd_ff      <= q_rd_in;
         q_cnt_ff     <= q_cnt_in;
      end
   end

endmodule

>>> hdl/dgb_checker.sv
// ----------------------------------------------------------------------------
// dgb_checker
// Port-level checks of the depth-to-gray converter, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dgb_checker import dgb_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [GRAY_W-1:0] gray_byte,
   input logic              is_profile,
   input logic              end_of_frame
);

   logic              rsp_prof;
   logic              rsp_stall;
   logic [GRAY_W+1:0] rsp_word;

   // Response conditions and the whole payload as one word.
   assign rsp_prof  = rsp_valid && is_profile;
   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_word  = {gray_byte, is_profile, end_of_frame};

   // After reset the memory is being cleared: no request, no response.
   `DGB_ASSERT_NEXT_ALWAYS(a_reset_quiet, clock, reset, !req_ready && !rsp_valid)

   // The last pixel of a frame always lies in a profile row.
   `DGB_ASSERT_IMPLY(a_eof_in_profile, clock, reset, rsp_valid && end_of_frame, is_profile)

   // A saturated byte never starts or lowers a band minimum.
   `DGB_ASSERT_IMPLY(a_profile_not_sat, clock, reset, rsp_prof, gray_byte != GRAY_W'(GRAY_MAX))

   // A stalled response holds its payload.
   `DGB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_word))

endmodule

bind depth_to_gray_with_band_minima dgb_checker u_dgb_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .gray_byte    (rsp_ch.gray_byte),
   .is_profile   (rsp_ch.is_profile),
   .end_of_frame (rsp_ch.end_of_frame)
);
